// ===== src/assert_macros.svh =====
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ffha_pkg.sv =====
`timescale 1ns / 1ps

package ffha_pkg;

  localparam int HEAP_BYTES_DEF   = 32768;
  localparam int HEADER_BYTES_DEF = 8;

  localparam int REQ_W      = 16;
  localparam int OFF_W      = 15;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_REQUEST = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_REQUEST = 1'b1;

  localparam logic [REQ_W-1:0] MIN_REQUEST_RST = 16'd16;
  localparam logic [REQ_W-1:0] MAX_REQUEST_RST = 16'd16384;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [REQ_W-1:0] request_size;
    logic [OFF_W-1:0] payload_offset;
  } in_req_t;

  typedef struct packed {
    logic             success;
    logic [OFF_W-1:0] granted_offset;
  } out_res_t;

  typedef struct packed {
    logic capture;
    logic do_free;
    logic step;
    logic claim;
    logic write_rem;
    logic respond;
    logic resp_ok;
  } ffha_cmd_t;

  typedef struct packed {
    logic is_free;
    logic bad_req;
    logic found;
    logic past_end;
  } ffha_stat_t;

endpackage

// ===== src/ffha_ctrl.sv =====
`timescale 1ns / 1ps

module ffha_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  ffha_pkg::ffha_stat_t stat,
  output ffha_pkg::ffha_cmd_t  cmd,
  output logic               busy
);
  import ffha_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_WALK,
    S_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.is_free) begin
          cmd.do_free = 1'b1;
          cmd.respond = 1'b1;
          cmd.resp_ok = 1'b1;
          state_nxt   = S_IDLE;
        end else if (stat.bad_req) begin
          cmd.respond = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (stat.found) begin
          cmd.claim = 1'b1;
          state_nxt = S_FINISH;
        end else if (stat.past_end) begin
          cmd.respond = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_FINISH: begin
        cmd.write_rem = 1'b1;
        cmd.respond   = 1'b1;
        cmd.resp_ok   = 1'b1;
        state_nxt     = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

// ===== src/ffha_datapath.sv =====
`timescale 1ns / 1ps

module ffha_datapath #(
  parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ffha_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ffha_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  ffha_pkg::in_req_t                   in_data,
  input  ffha_pkg::ffha_cmd_t                 cmd,
  output ffha_pkg::ffha_stat_t                stat,
  output logic                                out_valid,
  output ffha_pkg::out_res_t                  out_data
);
  import ffha_pkg::*;

  localparam int AW = $clog2(HEAP_BYTES);
  localparam int SW = $clog2(HEAP_BYTES + 1);
  localparam int CW = ((SW > REQ_W) ? SW : REQ_W) + 2;

  localparam logic [CW-1:0] HEAP_C    = CW'(HEAP_BYTES);
  localparam logic [CW-1:0] HDR_C     = CW'(HEADER_BYTES);
  localparam logic [SW-1:0] INIT_SIZE = SW'(HEAP_BYTES - HEADER_BYTES);

  // header store, flag and size kept apart so a free touches the flag only
  logic          flag_mem [HEAP_BYTES];
  logic [SW-1:0] size_mem [HEAP_BYTES];

  logic [REQ_W-1:0] min_req_r;
  logic [REQ_W-1:0] max_req_r;
  in_req_t          req_r;
  logic [AW-1:0]    cur_r;
  logic             run_r;
  logic [AW-1:0]    run_at_r;
  logic [CW-1:0]    run_size_r;
  logic [AW-1:0]    claim_at_r;
  logic [CW-1:0]    total_r;
  logic             split_r;
  logic             rd_flag_r;
  logic [SW-1:0]    rd_size_r;
  logic             ov_flag_r;
  logic             ov_size_r;
  logic             rd_ovf_r;
  logic             rd_ovs_r;
  logic             out_valid_r;
  out_res_t         out_data_r;

  logic [CW-1:0] req_w;
  logic          avail;
  logic [CW-1:0] bsz;
  logic [CW-1:0] cur_next;
  logic          blk_exact;
  logic          blk_split;
  logic [CW-1:0] run_size_upd;
  logic [AW-1:0] run_at_upd;
  logic          run_exact;
  logic          run_split;
  logic [AW-1:0] fit_at;
  logic [CW-1:0] fit_total;
  logic          fit_split;
  logic [CW-1:0] poff_w;
  logic [CW-1:0] free_h;
  logic          free_ok;
  logic [CW-1:0] rem_at;
  logic [CW-1:0] rem_size;
  logic          rem_in;
  logic [CW-1:0] grant_w;
  logic [AW-1:0] rd_addr;
  logic          wr_flag_en;
  logic          wr_size_en;
  logic [AW-1:0] wr_addr;
  logic          wr_flag;
  logic [SW-1:0] wr_size;

  assign req_w = CW'(req_r.request_size);
  assign avail = rd_ovf_r ? 1'b1 : rd_flag_r;
  assign bsz   = rd_ovs_r ? CW'(INIT_SIZE) : CW'(rd_size_r);

  assign cur_next  = CW'(cur_r) + bsz + HDR_C;
  assign blk_exact = avail && (bsz == req_w);
  assign blk_split = avail && (bsz >= req_w + HDR_C);

  assign run_size_upd = run_r ? (run_size_r + bsz + HDR_C) : bsz;
  assign run_at_upd   = run_r ? run_at_r : cur_r;
  assign run_exact    = avail && (run_size_upd == req_w);
  assign run_split    = avail && (req_w + HDR_C <= run_size_upd);

  always_comb begin
    priority if (blk_exact) begin
      fit_at    = cur_r;
      fit_total = bsz;
      fit_split = 1'b0;
    end else if (blk_split) begin
      fit_at    = cur_r;
      fit_total = bsz;
      fit_split = 1'b1;
    end else if (run_exact) begin
      fit_at    = run_at_upd;
      fit_total = run_size_upd;
      fit_split = 1'b0;
    end else begin
      fit_at    = run_at_upd;
      fit_total = run_size_upd;
      fit_split = 1'b1;
    end
  end

  assign poff_w  = CW'(req_r.payload_offset);
  assign free_h  = poff_w - HDR_C;
  assign free_ok = (poff_w >= HDR_C) && (free_h < HEAP_C);

  assign rem_at   = CW'(claim_at_r) + req_w + HDR_C;
  assign rem_size = total_r - req_w - HDR_C;
  assign rem_in   = rem_at < HEAP_C;

  assign grant_w = CW'(claim_at_r) + HDR_C;

  assign stat.is_free  = (req_r.kind == KIND_FREE);
  assign stat.bad_req  = (req_r.request_size < min_req_r) || (req_r.request_size > max_req_r);
  assign stat.found    = blk_exact || blk_split || run_exact || run_split;
  assign stat.past_end = cur_next >= HEAP_C;

  assign rd_addr = cmd.step ? cur_next[AW-1:0] : cur_r;

  always_comb begin
    wr_flag_en = 1'b0;
    wr_size_en = 1'b0;
    wr_addr    = '0;
    wr_flag    = 1'b0;
    wr_size    = '0;
    priority if (cmd.do_free) begin
      wr_flag_en = free_ok;
      wr_addr    = free_h[AW-1:0];
      wr_flag    = 1'b1;
    end else if (cmd.claim) begin
      wr_flag_en = 1'b1;
      wr_size_en = 1'b1;
      wr_addr    = fit_at;
      wr_flag    = 1'b0;
      wr_size    = SW'(req_w);
    end else if (cmd.write_rem) begin
      wr_flag_en = split_r && rem_in;
      wr_size_en = split_r && rem_in;
      wr_addr    = rem_at[AW-1:0];
      wr_flag    = 1'b1;
      wr_size    = SW'(rem_size);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_flag_en) begin
      flag_mem[wr_addr] <= wr_flag;
    end
    if (wr_size_en) begin
      size_mem[wr_addr] <= wr_size;
    end
    rd_flag_r <= flag_mem[rd_addr];
    rd_size_r <= size_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_req_r   <= MIN_REQUEST_RST;
      max_req_r   <= MAX_REQUEST_RST;
      ov_flag_r   <= 1'b1;
      ov_size_r   <= 1'b1;
      rd_ovf_r    <= 1'b0;
      rd_ovs_r    <= 1'b0;
      cur_r       <= '0;
      run_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MIN_REQUEST: min_req_r <= cfg_wdata;
          CFG_MAX_REQUEST: max_req_r <= cfg_wdata;
        endcase
      end
      // offset 0 reads its reset header until first written
      if (wr_flag_en && (wr_addr == '0)) begin
        ov_flag_r <= 1'b0;
      end
      if (wr_size_en && (wr_addr == '0)) begin
        ov_size_r <= 1'b0;
      end
      rd_ovf_r <= ov_flag_r && (rd_addr == '0);
      rd_ovs_r <= ov_size_r && (rd_addr == '0);
      if (cmd.capture) begin
        cur_r <= '0;
        run_r <= 1'b0;
      end else if (cmd.step) begin
        cur_r <= cur_next[AW-1:0];
        run_r <= avail;
      end
      out_valid_r <= cmd.respond;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_data;
    end
    if (cmd.step) begin
      run_at_r   <= run_at_upd;
      run_size_r <= avail ? run_size_upd : '0;
    end
    if (cmd.claim) begin
      claim_at_r <= fit_at;
      total_r    <= fit_total;
      split_r    <= fit_split;
    end
    if (cmd.respond) begin
      out_data_r.success        <= cmd.resp_ok;
      out_data_r.granted_offset <= (cmd.resp_ok && (req_r.kind == KIND_ALLOC)) ?
                                   grant_w[OFF_W-1:0] : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/first_fit_heap_allocator.sv =====
`timescale 1ns / 1ps
// channel   ports                                    handshake
// request   start, in_data, busy                     taken when start && !busy
// result    out_valid, out_data                      one-cycle strobe, no stall
// config    cfg_we, cfg_index, cfg_wdata             written when cfg_we
//
// a free or an out-of-bounds allocation is answered from the check state, with no header walk
// a granted allocation walks the headers, one header per cycle through the single read
// port of the header store, then claims the block and writes any remainder; a walk off the heap is refused
// synchronous active-low reset; offset 0 holds one free block over the heap
// busy stays high until the result strobe; results cannot be held off

module first_fit_heap_allocator #(
  parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  ffha_pkg::in_req_t               in_data,
  output logic                            busy,
  output logic                            out_valid,
  output ffha_pkg::out_res_t              out_data,
  input  logic                            cfg_we,
  input  logic [ffha_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ffha_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ffha_pkg::*;

  ffha_cmd_t  cmd;
  ffha_stat_t stat;

  ffha_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  ffha_datapath #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== src/ffha_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ffha_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input ffha_pkg::out_res_t out_data
);
  import ffha_pkg::*;

  `ASSERT_NXT(a_accept_busy, start && !busy, busy, "busy not raised after request")
  `ASSERT_IMP(a_result_idle, out_valid, !busy, "result while busy")
  `ASSERT_NXT(a_single_strobe, out_valid, !out_valid, "result strobe longer than one cycle")
  `ASSERT_IMP(a_fail_zero, out_valid && !out_data.success, out_data.granted_offset == '0, "refusal with nonzero offset")
  `ASSERT_IMP(a_after_work, out_valid, $past(busy), "result without a request in flight")

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
